// File: rtl/dhsb_pkg.sv
// Package for the depth hole search and back-projection block.
// Holds window geometry, arithmetic widths, register codes and the
// command, status and configuration structs shared by the register file, controller, datapath and top.
package dhsb_pkg;

    localparam int RADIUS     = 5;
    localparam int COORD_BITS = 12;

    localparam int WIN_SIDE  = 2 * RADIUS + 1;
    localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
    localparam int WIN_AW    = $clog2(WIN_CELLS);
    localparam int WS_W      = $clog2(WIN_SIDE);
    localparam int RING_W    = $clog2(RADIUS + 1);

    localparam int DEPTH_W   = 16;
    localparam int INTR_W    = 16;
    localparam int DIM_REG_W = 13;
    localparam int DIM_W     = COORD_BITS + 1;
    localparam int DIM_MAX   = 1 << COORD_BITS;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam int DIFF_W  = ((COORD_BITS + 4 > INTR_W) ? COORD_BITS + 4 : INTR_W) + 1;
    localparam int PROD_W  = DIFF_W + DEPTH_W + 1;
    localparam int MAG_W   = DIFF_W + DEPTH_W - 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int DIV_CW  = $clog2(DIV_STEPS);

    localparam int POS_W = 29;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TARGET_COL    = 3'd0,
        CFG_TARGET_ROW    = 3'd1,
        CFG_IMAGE_WIDTH   = 3'd2,
        CFG_IMAGE_HEIGHT  = 3'd3,
        CFG_PRINCIPAL_COL = 3'd4,
        CFG_PRINCIPAL_ROW = 3'd5,
        CFG_FOCAL_COL     = 3'd6,
        CFG_FOCAL_ROW     = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [COORD_BITS-1:0] target_col;
        logic [COORD_BITS-1:0] target_row;
        logic [DIM_W-1:0]      width_eff;
        logic [DIM_W-1:0]      height_eff;
        logic [INTR_W-1:0]     principal_col;
        logic [INTR_W-1:0]     principal_row;
        logic [INTR_W-1:0]     focal_col_eff;
        logic [INTR_W-1:0]     focal_row_eff;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_run;
        logic diff_load;
        logic mul_load;
        logic div_load;
        logic div_step;
        logic pos_store;
        logic axis;
        logic win_clear;
    } t_cmd;

    typedef struct packed {
        logic scan_hit;
        logic scan_miss;
        logic div_last;
    } t_status;

    function automatic logic [WIN_AW-1:0] win_addr(input logic [WS_W-1:0] col,
                                                   input logic [WS_W-1:0] row);
        return WIN_AW'(int'(row) * WIN_SIDE + int'(col));
    endfunction

endpackage

// File: rtl/dhsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dhsb_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 121,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/dhsb_cfg.sv
// Configuration register file for the depth hole search block.
// Depends on dhsb_pkg; presents t_cfg with the image size and focal lengths clamped.
module dhsb_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [dhsb_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [dhsb_pkg::CFG_DW-1:0] i_cfg_data,
    output dhsb_pkg::t_cfg           o_cfg
);
    import dhsb_pkg::*;

    logic [COORD_BITS-1:0] r_target_col;
    logic [COORD_BITS-1:0] r_target_row;
    logic [DIM_REG_W-1:0]  r_image_width;
    logic [DIM_REG_W-1:0]  r_image_height;
    logic [INTR_W-1:0]     r_principal_col;
    logic [INTR_W-1:0]     r_principal_row;
    logic [INTR_W-1:0]     r_focal_col;
    logic [INTR_W-1:0]     r_focal_row;

    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_REG_W-1:0] val);
        logic [DIM_W-1:0] res;
        if (val == '0) begin
            res = DIM_W'(1);
        end else if (32'(val) > DIM_MAX) begin
            res = DIM_W'(DIM_MAX);
        end else begin
            res = DIM_W'(val);
        end
        return res;
    endfunction

    function automatic logic [INTR_W-1:0] focal_eff(input logic [INTR_W-1:0] val);
        return (val == '0) ? INTR_W'(1) : val;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_col    <= '0;
            r_target_row    <= '0;
            r_image_width   <= DIM_REG_W'(640);
            r_image_height  <= DIM_REG_W'(480);
            r_principal_col <= INTR_W'(5120);
            r_principal_row <= INTR_W'(3840);
            r_focal_col     <= INTR_W'(9600);
            r_focal_row     <= INTR_W'(9600);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TARGET_COL:    r_target_col    <= i_cfg_data[COORD_BITS-1:0];
                CFG_TARGET_ROW:    r_target_row    <= i_cfg_data[COORD_BITS-1:0];
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[DIM_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[DIM_REG_W-1:0];
                CFG_PRINCIPAL_COL: r_principal_col <= i_cfg_data[INTR_W-1:0];
                CFG_PRINCIPAL_ROW: r_principal_row <= i_cfg_data[INTR_W-1:0];
                CFG_FOCAL_COL:     r_focal_col     <= i_cfg_data[INTR_W-1:0];
                CFG_FOCAL_ROW:     r_focal_row     <= i_cfg_data[INTR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.target_col    = r_target_col;
        o_cfg.target_row    = r_target_row;
        o_cfg.width_eff     = dim_eff(r_image_width);
        o_cfg.height_eff    = dim_eff(r_image_height);
        o_cfg.principal_col = r_principal_col;
        o_cfg.principal_row = r_principal_row;
        o_cfg.focal_col_eff = focal_eff(r_focal_col);
        o_cfg.focal_row_eff = focal_eff(r_focal_row);
    end

endmodule

// File: rtl/dhsb_ctrl.sv
// Controller for the depth hole search block: stream, window scan,
// per-axis multiply and divide, result hand-off. Depends on dhsb_pkg.
module dhsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_pixel,
    input  logic              i_out_stall,
    input  dhsb_pkg::t_status i_status,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output dhsb_pkg::t_cmd    o_cmd
);
    import dhsb_pkg::*;

    typedef enum logic [2:0] {
        ST_STREAM,
        ST_SCAN,
        ST_DIFF,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_STORE,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            ST_STREAM: begin
                if (i_in_valid && i_last_pixel) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_hit) begin
                    n_state = ST_DIFF;
                    n_axis  = 1'b0;
                end else if (i_status.scan_miss) begin
                    n_state = ST_OUT;
                end
            end
            ST_DIFF:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_DLOAD;
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (r_axis) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIFF;
                    n_axis  = 1'b1;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_STREAM;
                end
            end
            default: n_state = ST_STREAM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_STREAM;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        o_cmd.capture   = (r_state == ST_STREAM) && i_in_valid;
        o_cmd.scan_init = (r_state == ST_STREAM) && i_in_valid && i_last_pixel;
        o_cmd.scan_run  = (r_state == ST_SCAN);
        o_cmd.diff_load = (r_state == ST_DIFF);
        o_cmd.mul_load  = (r_state == ST_MUL);
        o_cmd.div_load  = (r_state == ST_DLOAD);
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.pos_store = (r_state == ST_STORE);
        o_cmd.axis      = r_axis;
        o_cmd.win_clear = (r_state == ST_OUT) && !i_out_stall;
    end

    assign o_in_stall  = (r_state != ST_STREAM);
    assign o_out_valid = (r_state == ST_OUT);

endmodule

// File: rtl/dhsb_dpath.sv
// Datapath for the depth hole search block: raster counters, window RAM
// with valid bits, ring scan, multiplier, restoring divider and result
// registers. Depends on dhsb_pkg and dhsb_ram.
module dhsb_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dhsb_pkg::t_cmd                       i_cmd,
    input  dhsb_pkg::t_cfg                       i_cfg,
    input  logic [dhsb_pkg::DEPTH_W-1:0]         i_depth_sample,
    output dhsb_pkg::t_status                    o_status,
    output logic                                 o_found,
    output logic [dhsb_pkg::COORD_BITS-1:0]      o_hit_col,
    output logic [dhsb_pkg::COORD_BITS-1:0]      o_hit_row,
    output logic [dhsb_pkg::DEPTH_W-1:0]         o_depth_mm,
    output logic signed [dhsb_pkg::POS_W-1:0]    o_pos_x_mm,
    output logic signed [dhsb_pkg::POS_W-1:0]    o_pos_y_mm
);
    import dhsb_pkg::*;

    localparam int CW = COORD_BITS;
    localparam logic signed [CW:0]     RAD_C = (CW+1)'(RADIUS);
    localparam logic [WS_W-1:0]        RAD_W = WS_W'(RADIUS);
    localparam logic [RING_W-1:0]      RAD_R = RING_W'(RADIUS);
    localparam logic [MAG_W-1:0]       POS_MAX_MAG = MAG_W'((1 << (POS_W - 1)) - 1);
    localparam logic [MAG_W-1:0]       POS_MIN_MAG = MAG_W'(1 << (POS_W - 1));

    // raster position and capture
    logic [CW-1:0]          r_pix_col, r_pix_row;
    logic                   r_overrun;
    logic signed [CW:0]     cap_dc, cap_dr;
    logic                   cap_in_img, cap_in_win, cap_wr;
    logic [WS_W-1:0]        cap_col, cap_row;
    logic [WIN_AW-1:0]      cap_addr;
    logic                   col_wrap, row_wrap;

    // window valid bits
    logic [WIN_CELLS-1:0]   r_vld;

    // scan
    logic [RING_W-1:0]      r_ring;
    logic [WS_W-1:0]        r_cu, r_cv;
    logic                   r_issue_done;
    logic [WS_W-1:0]        ring_lo, ring_hi, next_lo;
    logic                   issue;
    logic [WIN_AW-1:0]      scan_addr;
    logic signed [CW+1:0]   scan_nc, scan_nr;
    logic                   scan_inb;
    logic                   r_s1_valid, r_s1_inb, r_s1_vld;
    logic [CW-1:0]          r_s1_col, r_s1_row;
    logic [DEPTH_W-1:0]     ram_rdata;
    logic                   scan_hit;

    // arithmetic
    logic [CW-1:0]          sel_coord;
    logic [INTR_W-1:0]      sel_prin, sel_focal;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic                   r_neg;
    logic [MAG_W-1:0]       prod_mag;
    logic [MAG_W-1:0]       r_div_q;
    logic [INTR_W-1:0]      r_div_rem;
    logic [DIV_CW-1:0]      r_div_cnt;
    logic [INTR_W:0]        div_trial;
    logic                   div_bit;
    logic [MAG_W-1:0]       q_neg;
    logic [POS_W-1:0]       pos_sat;

    // result registers
    logic                   r_found;
    logic [CW-1:0]          r_hit_col, r_hit_row;
    logic [DEPTH_W-1:0]     r_z;
    logic [POS_W-1:0]       r_pos_x, r_pos_y;

    // ---------------- capture ----------------
    always_comb begin
        cap_dc     = $signed({1'b0, r_pix_col}) - $signed({1'b0, i_cfg.target_col});
        cap_dr     = $signed({1'b0, r_pix_row}) - $signed({1'b0, i_cfg.target_row});
        cap_in_img = ({1'b0, r_pix_col} < i_cfg.width_eff)
                  && ({1'b0, r_pix_row} < i_cfg.height_eff);
        cap_in_win = (cap_dc >= -RAD_C) && (cap_dc <= RAD_C)
                  && (cap_dr >= -RAD_C) && (cap_dr <= RAD_C);
        cap_col    = WS_W'(cap_dc + RAD_C);
        cap_row    = WS_W'(cap_dr + RAD_C);
        cap_addr   = win_addr(cap_col, cap_row);
        cap_wr     = i_cmd.capture && !r_overrun && cap_in_img && cap_in_win;
        col_wrap   = ({1'b0, r_pix_col} + DIM_W'(1)) >= i_cfg.width_eff;
        row_wrap   = ({1'b0, r_pix_row} + DIM_W'(1)) >= i_cfg.height_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_col <= '0;
            r_pix_row <= '0;
            r_overrun <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_pix_col <= '0;
            r_pix_row <= '0;
            r_overrun <= 1'b0;
        end else if (i_cmd.capture && !r_overrun) begin
            if (col_wrap) begin
                r_pix_col <= '0;
                if (row_wrap) begin
                    r_overrun <= 1'b1;
                end else begin
                    r_pix_row <= r_pix_row + CW'(1);
                end
            end else begin
                r_pix_col <= r_pix_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.win_clear) begin
            r_vld <= '0;
        end else if (cap_wr) begin
            r_vld[cap_addr] <= 1'b1;
        end
    end

    dhsb_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (WIN_CELLS)
    ) u_win_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cap_wr),
        .i_wr_addr (cap_addr),
        .i_wr_data (i_depth_sample),
        .i_rd_addr (scan_addr),
        .o_rd_data (ram_rdata)
    );

    // ---------------- ring scan ----------------
    always_comb begin
        ring_lo   = RAD_W - WS_W'(r_ring);
        ring_hi   = RAD_W + WS_W'(r_ring);
        next_lo   = ring_lo - WS_W'(1);
        scan_addr = win_addr(r_cu, r_cv);
        scan_nc   = $signed((CW+2)'(i_cfg.target_col)) + $signed((CW+2)'(r_cu))
                  - $signed((CW+2)'(RADIUS));
        scan_nr   = $signed((CW+2)'(i_cfg.target_row)) + $signed((CW+2)'(r_cv))
                  - $signed((CW+2)'(RADIUS));
        scan_inb  = (scan_nc >= 0) && (scan_nc < $signed((CW+2)'(i_cfg.width_eff)))
                 && (scan_nr >= 0) && (scan_nr < $signed((CW+2)'(i_cfg.height_eff)));
        scan_hit  = r_s1_valid && r_s1_inb && r_s1_vld && (ram_rdata != '0);
        issue     = i_cmd.scan_run && !r_issue_done && !scan_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring       <= RING_W'(1);
            r_cu         <= RAD_W - WS_W'(1);
            r_cv         <= RAD_W - WS_W'(1);
            r_issue_done <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            if (i_cmd.scan_init) begin
                r_ring       <= RING_W'(1);
                r_cu         <= RAD_W - WS_W'(1);
                r_cv         <= RAD_W - WS_W'(1);
                r_issue_done <= 1'b0;
            end else if (issue) begin
                priority if (r_cv != ring_hi) begin
                    r_cv <= r_cv + WS_W'(1);
                end else if (r_cu != ring_hi) begin
                    r_cu <= r_cu + WS_W'(1);
                    r_cv <= ring_lo;
                end else if (r_ring != RAD_R) begin
                    r_ring <= r_ring + RING_W'(1);
                    r_cu   <= next_lo;
                    r_cv   <= next_lo;
                end else begin
                    r_issue_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_inb <= scan_inb;
        r_s1_vld <= r_vld[scan_addr];
        r_s1_col <= scan_nc[CW-1:0];
        r_s1_row <= scan_nr[CW-1:0];
    end

    // ---------------- multiply and divide ----------------
    always_comb begin
        sel_coord = i_cmd.axis ? r_hit_row : r_hit_col;
        sel_prin  = i_cmd.axis ? i_cfg.principal_row : i_cfg.principal_col;
        sel_focal = i_cmd.axis ? i_cfg.focal_row_eff : i_cfg.focal_col_eff;
        prod_mag  = r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);
        div_trial = {r_div_rem, r_div_q[MAG_W-1]};
        div_bit   = (div_trial >= {1'b0, sel_focal});
        q_neg     = ~r_div_q + MAG_W'(1);
        if (!r_neg) begin
            pos_sat = (r_div_q > POS_MAX_MAG) ? POS_MAX_MAG[POS_W-1:0] : r_div_q[POS_W-1:0];
        end else begin
            pos_sat = (r_div_q > POS_MIN_MAG) ? POS_MIN_MAG[POS_W-1:0] : q_neg[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_load) begin
            r_diff <= $signed(DIFF_W'({sel_coord, 4'b0000})) - $signed(DIFF_W'(sel_prin));
        end
        if (i_cmd.mul_load) begin
            r_prod <= PROD_W'(r_diff * $signed({1'b0, r_z}));
        end
        if (i_cmd.div_load) begin
            r_neg     <= r_prod[PROD_W-1];
            r_div_q   <= prod_mag;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_q   <= {r_div_q[MAG_W-2:0], div_bit};
            r_div_rem <= div_bit ? INTR_W'(div_trial - {1'b0, sel_focal})
                                 : div_trial[INTR_W-1:0];
            r_div_cnt <= r_div_cnt + DIV_CW'(1);
        end
    end

    // ---------------- result ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_found   <= 1'b0;
            r_hit_col <= '0;
            r_hit_row <= '0;
            r_z       <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
        end else if (i_cmd.scan_run && scan_hit) begin
            r_found   <= 1'b1;
            r_hit_col <= r_s1_col;
            r_hit_row <= r_s1_row;
            r_z       <= ram_rdata;
        end else if (i_cmd.pos_store) begin
            if (i_cmd.axis) begin
                r_pos_y <= pos_sat;
            end else begin
                r_pos_x <= pos_sat;
            end
        end
    end

    always_comb begin
        o_status.scan_hit  = scan_hit;
        o_status.scan_miss = r_issue_done && !r_s1_valid;
        o_status.div_last  = (r_div_cnt == DIV_CW'(DIV_STEPS - 1));
    end

    assign o_found    = r_found;
    assign o_hit_col  = r_hit_col;
    assign o_hit_row  = r_hit_row;
    assign o_depth_mm = r_z;
    assign o_pos_x_mm = $signed(r_pos_x);
    assign o_pos_y_mm = $signed(r_pos_y);

endmodule

// File: rtl/depth_hole_search_backproject.sv
// Top level of the depth hole search and back-projection block.
// Depends on dhsb_pkg, dhsb_cfg, dhsb_ctrl and dhsb_dpath.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | sink      | i_in_valid/o_in_stall   | i_depth_sample, i_last_pixel
//   out     | source    | o_out_valid/i_out_stall | o_found, o_hit_col, o_hit_row,
//           |           |                         | o_depth_mm, o_pos_x_mm, o_pos_y_mm
//   cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Pixels are taken one per cycle while streaming. After the last pixel of a
// frame the window scan reads one window entry a cycle, 285 reads over rings
// 1 to 5, then each axis runs subtract, multiply, divider load, a 32-step
// divider and saturate before the result is offered.
// No pixel is taken from the last pixel until the result leaves the output.
// Reset is synchronous; the window valid bits clear at once, no sweep.
module depth_hole_search_backproject (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [dhsb_pkg::DEPTH_W-1:0]         i_depth_sample,
    input  logic                                 i_last_pixel,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_found,
    output logic [dhsb_pkg::COORD_BITS-1:0]      o_hit_col,
    output logic [dhsb_pkg::COORD_BITS-1:0]      o_hit_row,
    output logic [dhsb_pkg::DEPTH_W-1:0]         o_depth_mm,
    output logic signed [dhsb_pkg::POS_W-1:0]    o_pos_x_mm,
    output logic signed [dhsb_pkg::POS_W-1:0]    o_pos_y_mm,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dhsb_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [dhsb_pkg::CFG_DW-1:0]          i_cfg_data
);
    import dhsb_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dhsb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dhsb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_pixel (i_last_pixel),
        .i_out_stall  (i_out_stall),
        .i_status     (status),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cmd        (cmd)
    );

    dhsb_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_depth_sample (i_depth_sample),
        .o_status       (status),
        .o_found        (o_found),
        .o_hit_col      (o_hit_col),
        .o_hit_row      (o_hit_row),
        .o_depth_mm     (o_depth_mm),
        .o_pos_x_mm     (o_pos_x_mm),
        .o_pos_y_mm     (o_pos_y_mm)
    );

endmodule

// File: rtl/dhsb_checker.sv
// Port-level checker for the depth hole search block, bound to the top.
// Depends on dhsb_pkg.
module dhsb_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 i_last_pixel,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic                                 o_found,
    input logic [dhsb_pkg::COORD_BITS-1:0]      o_hit_col,
    input logic [dhsb_pkg::COORD_BITS-1:0]      o_hit_row,
    input logic [dhsb_pkg::DEPTH_W-1:0]         o_depth_mm,
    input logic signed [dhsb_pkg::POS_W-1:0]    o_pos_x_mm,
    input logic signed [dhsb_pkg::POS_W-1:0]    o_pos_y_mm
);
    import dhsb_pkg::*;

    a_no_input_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("item taken while a result is pending");

    a_last_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_pixel) |=> (o_in_stall && !o_out_valid))
        else $error("frame end did not start the search");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_found)
            && $stable(o_pos_x_mm) && $stable(o_pos_y_mm) && $stable(o_depth_mm)))
        else $error("stalled result changed");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_hit_col == '0 && o_hit_row == '0
            && o_depth_mm == '0 && o_pos_x_mm == '0 && o_pos_y_mm == '0))
        else $error("not-found result carries data");

    a_hit_has_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_depth_mm != '0))
        else $error("found result with zero depth");

endmodule

bind depth_hole_search_backproject dhsb_checker u_dhsb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_last_pixel (i_last_pixel),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_found      (o_found),
    .o_hit_col    (o_hit_col),
    .o_hit_row    (o_hit_row),
    .o_depth_mm   (o_depth_mm),
    .o_pos_x_mm   (o_pos_x_mm),
    .o_pos_y_mm   (o_pos_y_mm)
);

// File: verif/dhsb_result_checker.sv
`timescale 1ns / 1ps
// Result checker for depth_hole_search_backproject: mirrors the register file,
// captures the target window, searches it at frame end and back-projects the hit.
// Depends on dhsb_pkg; compares every output item with the oldest expected hit.
module dhsb_result_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [dhsb_pkg::DEPTH_W-1:0]         i_depth_sample,
    input  logic                                 i_last_pixel,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_found,
    input  logic [dhsb_pkg::COORD_BITS-1:0]      i_hit_col,
    input  logic [dhsb_pkg::COORD_BITS-1:0]      i_hit_row,
    input  logic [dhsb_pkg::DEPTH_W-1:0]         i_depth_mm,
    input  logic signed [dhsb_pkg::POS_W-1:0]    i_pos_x_mm,
    input  logic signed [dhsb_pkg::POS_W-1:0]    i_pos_y_mm,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [dhsb_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [dhsb_pkg::CFG_DW-1:0]          i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_found_frames
);
    import dhsb_pkg::*;

    localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_LO = -(longint'(1) << (POS_W - 1));

    typedef struct packed {
        logic                     found;
        logic [COORD_BITS-1:0]    col;
        logic [COORD_BITS-1:0]    row;
        logic [DEPTH_W-1:0]       depth;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_depth_hit;

    logic [DEPTH_W-1:0]   window_q [WIN_CELLS];
    int                   pix_col;
    int                   pix_row;
    bit                   past_end;
    logic [COORD_BITS-1:0] tgt_col;
    logic [COORD_BITS-1:0] tgt_row;
    logic [DIM_REG_W-1:0]  width_reg;
    logic [DIM_REG_W-1:0]  height_reg;
    logic [INTR_W-1:0]     ppt_col;
    logic [INTR_W-1:0]     ppt_row;
    logic [INTR_W-1:0]     foc_col;
    logic [INTR_W-1:0]     foc_row;
    t_depth_hit            expected_hits [$];
    int                    fails = 0;
    int                    found_frames = 0;

    function automatic int clip_dim(logic [DIM_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DIM_MAX) return DIM_MAX;
        return int'(v);
    endfunction

    function automatic logic signed [POS_W-1:0] back_project(int coord,
                                                            logic [INTR_W-1:0] ppt,
                                                            logic [INTR_W-1:0] foc,
                                                            logic [DEPTH_W-1:0] z);
        longint num;
        longint den;
        longint q;
        num = (longint'(coord) * 16 - longint'(ppt)) * longint'(z);
        den = (foc == 0) ? 64'sd1 : longint'(foc);
        q = num / den;
        if (q > POS_HI) q = POS_HI;
        else if (q < POS_LO) q = POS_LO;
        return POS_W'(q);
    endfunction

    function automatic void clear_frame();
        foreach (window_q[k]) window_q[k] = '0;
        pix_col  = 0;
        pix_row  = 0;
        past_end = 1'b0;
    endfunction

    function automatic t_depth_hit search_window();
        t_depth_hit h;
        int w;
        int ht;
        int tc;
        int tr;
        int nc;
        int nr;
        logic [DEPTH_W-1:0] d;
        h  = '0;
        w  = clip_dim(width_reg);
        ht = clip_dim(height_reg);
        tc = int'(tgt_col);
        tr = int'(tgt_row);
        for (int r = 1; r <= RADIUS && !h.found; r++)
            for (int du = -r; du <= r && !h.found; du++)
                for (int dv = -r; dv <= r && !h.found; dv++) begin
                    nc = tc + du;
                    nr = tr + dv;
                    if (nc >= 0 && nc < w && nr >= 0 && nr < ht) begin
                        d = window_q[(dv + RADIUS) * WIN_SIDE + du + RADIUS];
                        if (d != 0) begin
                            h.found = 1'b1;
                            h.col   = COORD_BITS'(nc);
                            h.row   = COORD_BITS'(nr);
                            h.depth = d;
                        end
                    end
                end
        if (h.found) begin
            h.pos_x = back_project(int'(h.col), ppt_col, foc_col, h.depth);
            h.pos_y = back_project(int'(h.row), ppt_row, foc_row, h.depth);
        end
        return h;
    endfunction

    function automatic void take_pixel(logic [DEPTH_W-1:0] sample, logic last);
        int w;
        int ht;
        int dc;
        int dr;
        t_depth_hit h;
        w  = clip_dim(width_reg);
        ht = clip_dim(height_reg);
        if (!past_end && pix_col < w && pix_row < ht) begin
            dc = pix_col - int'(tgt_col);
            dr = pix_row - int'(tgt_row);
            if (dc >= -RADIUS && dc <= RADIUS && dr >= -RADIUS && dr <= RADIUS)
                window_q[(dr + RADIUS) * WIN_SIDE + dc + RADIUS] = sample;
        end
        if (!past_end) begin
            if (pix_col + 1 >= w) begin
                pix_col = 0;
                if (pix_row + 1 >= ht) past_end = 1'b1;
                else pix_row++;
            end else begin
                pix_col++;
            end
        end
        if (last) begin
            h = search_window();
            if (h.found) found_frames++;
            expected_hits.push_back(h);
            clear_frame();
        end
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_depth_hit want;
        if (!i_rst_n) begin
            tgt_col    = '0;
            tgt_row    = '0;
            width_reg  = DIM_REG_W'(640);
            height_reg = DIM_REG_W'(480);
            ppt_col    = INTR_W'(5120);
            ppt_row    = INTR_W'(3840);
            foc_col    = INTR_W'(9600);
            foc_row    = INTR_W'(9600);
            clear_frame();
            expected_hits.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_TARGET_COL:    tgt_col    = i_cfg_data[COORD_BITS-1:0];
                    CFG_TARGET_ROW:    tgt_row    = i_cfg_data[COORD_BITS-1:0];
                    CFG_IMAGE_WIDTH:   width_reg  = i_cfg_data[DIM_REG_W-1:0];
                    CFG_IMAGE_HEIGHT:  height_reg = i_cfg_data[DIM_REG_W-1:0];
                    CFG_PRINCIPAL_COL: ppt_col    = i_cfg_data[INTR_W-1:0];
                    CFG_PRINCIPAL_ROW: ppt_row    = i_cfg_data[INTR_W-1:0];
                    CFG_FOCAL_COL:     foc_col    = i_cfg_data[INTR_W-1:0];
                    CFG_FOCAL_ROW:     foc_row    = i_cfg_data[INTR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) take_pixel(i_depth_sample, i_last_pixel);
            if (i_out_valid && !i_out_stall) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: result with none expected: found %0d col %0d row %0d depth %0d",
                             $time, i_found, i_hit_col, i_hit_row, i_depth_mm);
                    fails++;
                end else begin
                    want = expected_hits.pop_front();
                    check_field("found", want.found, i_found);
                    check_field("hit_col", want.col, i_hit_col);
                    check_field("hit_row", want.row, i_hit_row);
                    check_field("depth_mm", want.depth, i_depth_mm);
                    check_field("pos_x_mm", longint'(want.pos_x), longint'(i_pos_x_mm));
                    check_field("pos_y_mm", longint'(want.pos_y), longint'(i_pos_y_mm));
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= expected_hits.size();
        o_found_frames <= found_frames;
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for depth_hole_search_backproject: streams directed and random
// depth frames, programs the camera registers between frames, gives the verdict.
// Depends on dhsb_pkg, the block itself and dhsb_result_checker.
module tb;
    import dhsb_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 400;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [DEPTH_W-1:0]       depth_sample = '0;
    logic                     last_pixel = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     found;
    logic [COORD_BITS-1:0]    hit_col;
    logic [COORD_BITS-1:0]    hit_row;
    logic [DEPTH_W-1:0]       depth_mm;
    logic signed [POS_W-1:0] pos_x_mm;
    logic signed [POS_W-1:0] pos_y_mm;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IW-1:0]        cfg_index = '0;
    logic [CFG_DW-1:0]        cfg_data = '0;

    int fail_count;
    int pending;
    int found_frames;

    bit quiet = 1'b0;
    int w_eff = 640;
    int h_eff = 480;
    int frames_sent = 0;
    int pixels_sent = 0;
    int random_pixels = 0;
    int random_frames = 0;
    int calm_items = 0;
    int stall_left = 0;
    int run_left = 0;
    int idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    depth_hole_search_backproject dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_depth_sample (depth_sample),
        .i_last_pixel   (last_pixel),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_found        (found),
        .o_hit_col      (hit_col),
        .o_hit_row      (hit_row),
        .o_depth_mm     (depth_mm),
        .o_pos_x_mm     (pos_x_mm),
        .o_pos_y_mm     (pos_y_mm),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    dhsb_result_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_depth_sample (depth_sample),
        .i_last_pixel   (last_pixel),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_found        (found),
        .i_hit_col      (hit_col),
        .i_hit_row      (hit_row),
        .i_depth_mm     (depth_mm),
        .i_pos_x_mm     (pos_x_mm),
        .i_pos_y_mm     (pos_y_mm),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_found_frames (found_frames)
    );

    always @(posedge clk) begin
        if (quiet) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (run_left > 0) begin
            out_stall <= 1'b0;
            run_left  <= run_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
            run_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 150)
                                                      : $urandom_range(1, 12);
        end else begin
            out_stall <= 1'b0;
            run_left  <= $urandom_range(1, 12);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int dim_of(int r);
        if (r == 0) return 1;
        if (r > DIM_MAX) return DIM_MAX;
        return r;
    endfunction

    function automatic logic [CFG_DW-1:0] with_noise(int v, int bits);
        logic [CFG_DW-1:0] d;
        d = CFG_DW'(v);
        if ($urandom_range(0, 3) == 0) d = d | (CFG_DW'($urandom) << bits);
        return d;
    endfunction

    function automatic logic [DEPTH_W-1:0] rand_depth();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0001;
            default: return DEPTH_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [DEPTH_W-1:0] depth_for(int density);
        case (density)
            0:       return '0;
            1:       return ($urandom_range(0, 19) == 0) ? rand_depth() : 16'h0000;
            2:       return ($urandom_range(0, 2) == 0) ? rand_depth() : 16'h0000;
            default: return rand_depth();
        endcase
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return DIM_MAX;
            2:       return $urandom_range(DIM_MAX + 1, 8191);
            3:       return $urandom_range(11, 40);
            default: return $urandom_range(1, 10);
        endcase
    endfunction

    function automatic int pick_principal();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int pick_focal();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 16;
            2:       return $urandom_range(1, 40);
            default: return $urandom_range(16, 65535);
        endcase
    endfunction

    task automatic send_pixel(logic [DEPTH_W-1:0] d, bit last);
        int gap;
        if (calm_items > 0) begin
            calm_items--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end else if ($urandom_range(0, 15) == 0) begin
            calm_items = $urandom_range(20, 100);
        end
        in_valid     <= 1'b1;
        depth_sample <= d;
        last_pixel   <= last;
        do @(posedge clk); while (in_stall);
        pixels_sent++;
        if (last) frames_sent++;
    endtask

    task automatic send_run(int count, logic [DEPTH_W-1:0] d, bit end_frame);
        for (int i = 0; i < count; i++) send_pixel(d, end_frame && i == count - 1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_setup(int wr, int hr, int tc, int tr,
                                 int pc, int pr, int fc, int fr);
        write_reg(CFG_TARGET_COL, with_noise(tc, COORD_BITS));
        write_reg(CFG_TARGET_ROW, with_noise(tr, COORD_BITS));
        write_reg(CFG_IMAGE_WIDTH, with_noise(wr, DIM_REG_W));
        write_reg(CFG_IMAGE_HEIGHT, with_noise(hr, DIM_REG_W));
        write_reg(CFG_PRINCIPAL_COL, CFG_DW'(pc));
        write_reg(CFG_PRINCIPAL_ROW, CFG_DW'(pr));
        write_reg(CFG_FOCAL_COL, CFG_DW'(fc));
        write_reg(CFG_FOCAL_ROW, CFG_DW'(fr));
        cfg_valid <= 1'b0;
        w_eff = dim_of(wr);
        h_eff = dim_of(hr);
    endtask

    task automatic random_setup();
        int wr;
        int hr;
        int tc;
        int tr;
        wr = pick_dim();
        hr = pick_dim();
        if (dim_of(wr) * dim_of(hr) > 400) begin
            tc = $urandom_range(0, 30);
            tr = $urandom_range(0, 2);
        end else if ($urandom_range(0, 9) == 0) begin
            tc = $urandom_range(0, 4095);
            tr = $urandom_range(0, 4095);
        end else begin
            tc = $urandom_range(0, dim_of(wr) + 2 * RADIUS);
            tr = $urandom_range(0, dim_of(hr) + 2 * RADIUS);
        end
        program_setup(wr, hr, tc, tr, pick_principal(), pick_principal(),
                      pick_focal(), pick_focal());
    endtask

    task automatic random_frame();
        int full;
        int n;
        int density;
        full = w_eff * h_eff;
        if (full > 400) begin
            n = $urandom_range(1, 60);
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2: n = $urandom_range(1, full);
                3, 4, 5: n = full + $urandom_range(1, 10);
                default: n = full;
            endcase
        end
        density = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) send_pixel(depth_for(density), i == n - 1);
        random_pixels += n;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0001, 1'b1);
        send_pixel(16'h0000, 1'b1);

        settle();
        program_setup(0, 0, 0, 0, 65535, 65535, 0, 0);
        send_run(3, 16'hFFFF, 1'b1);

        settle();
        program_setup(8191, 8191, 3, 0, 0, 0, 16, 16);
        send_run(5, 16'h0000, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_run(2, 16'h0000, 1'b1);

        settle();
        program_setup(4, 2, 6, 1, 5120, 3840, 9600, 9600);
        send_run(3, 16'h0000, 1'b0);
        send_pixel(16'h0007, 1'b0);
        send_run(4, 16'h0000, 1'b1);

        while (random_pixels < 1800 || random_frames < 60) begin
            if (random_frames == 0 || $urandom_range(0, 2) == 0) begin
                settle();
                random_setup();
            end
            random_frame();
            random_frames++;
            if (random_pixels >= 1500 && random_frames >= 50) quiet <= 1'b1;
        end

        settle();
        $display("Streamed %0d depth pixels in %0d frames over random sizes, targets and optics.",
                 pixels_sent, frames_sent);
        $display("%0d frame ends found a depth, %0d found none.",
                 found_frames, frames_sent - found_frames);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/dhsb_pkg.sv
rtl/dhsb_ram.sv
rtl/dhsb_cfg.sv
rtl/dhsb_ctrl.sv
rtl/dhsb_dpath.sv
rtl/depth_hole_search_backproject.sv
rtl/dhsb_checker.sv
verif/dhsb_result_checker.sv
verif/tb.sv
